/* rtl/core/two_motor_speed_sync_pi_top_defines.svh */
// Assertion macros used by the checker file of the motor controller.
`ifndef TWO_MOTOR_SPEED_SYNC_PI_TOP_DEFINES_SVH
`define TWO_MOTOR_SPEED_SYNC_PI_TOP_DEFINES_SVH

// Same-cycle implication on aclk, off while aresetn is low
`define TMSS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication on aclk, off while aresetn is low
`define TMSS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/tmss_pkg.sv */
// Shared constants, codes and types of the two-motor speed sync controller.
package tmss_pkg;

    localparam int DUTY_MAX    = 1000;
    localparam int DUTY_W      = 10;
    localparam int MODE_W      = 3;
    localparam int CNT_W       = 16;
    localparam int TIME_W      = 32;
    localparam int RAMP_W      = 11;
    localparam int ERR_W       = 17;
    localparam int INTEG_W     = 16;
    localparam int LIMIT_W     = 15;
    localparam int GAIN_W      = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Drive modes
    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT    = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LEFT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_BACK     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STOP     = 3'd4;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_BUTTON = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_TARGET_BASE    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RAMP_STEP      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_KP_Q8          = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_KI_Q8          = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_DUTY      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_MS    = 3'd6;

    // Per-item control carried from the state stage into the PI datapath
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              upd;
        logic              clr;
        logic              pi_en;
        logic [RAMP_W-1:0] ramp;
        logic [DUTY_W-1:0] duty_a_fwd;
        logic [DUTY_W-1:0] duty_a_rev;
        logic [DUTY_W-1:0] duty_b_fwd;
        logic [DUTY_W-1:0] duty_b_rev;
    } tmss_ctrl_t;

    // One result transaction
    typedef struct packed {
        logic [MODE_W-1:0] drive_mode;
        logic [DUTY_W-1:0] duty_a_fwd;
        logic [DUTY_W-1:0] duty_a_rev;
        logic [DUTY_W-1:0] duty_b_fwd;
        logic [DUTY_W-1:0] duty_b_rev;
        logic              duty_update;
        logic              clear_encoders;
    } tmss_result_t;

endpackage

/* rtl/core/tmss_pi_datapath.sv */
// PI datapath: gain multiply stage, then sum, scale, clamp or fixed duties to result register.
module tmss_pi_datapath (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic [tmss_pkg::GAIN_W-1:0]            kp_q8,
    input  logic [tmss_pkg::GAIN_W-1:0]            ki_q8,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  tmss_pkg::tmss_ctrl_t                   in_ctrl,
    input  logic signed [tmss_pkg::ERR_W-1:0]      in_err,
    input  logic signed [tmss_pkg::INTEG_W-1:0]    in_integ,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output tmss_pkg::tmss_result_t                 out_result
);
    import tmss_pkg::*;

    localparam int KP_PROD_W = ERR_W + GAIN_W + 1;
    localparam int KI_PROD_W = INTEG_W + GAIN_W + 1;
    localparam int SUM_W     = KP_PROD_W + 1;
    localparam int CORR_W    = SUM_W - 8;
    localparam int DIFF_W    = CORR_W + 1;

    logic                        p_valid_reg;
    tmss_ctrl_t                  p_ctrl_reg;
    logic signed [KP_PROD_W-1:0] p_kp_prod_reg;
    logic signed [KI_PROD_W-1:0] p_ki_prod_reg;
    logic signed [KP_PROD_W-1:0] kp_prod;
    logic signed [KI_PROD_W-1:0] ki_prod;

    logic                        out_valid_reg;
    tmss_result_t                out_result_reg;
    tmss_result_t                out_result_next;

    logic                        out_adv;
    logic                        p_ready;
    logic signed [SUM_W-1:0]     sum;
    logic signed [SUM_W-1:0]     sum_biased;
    logic signed [CORR_W-1:0]    corr;
    logic signed [DIFF_W-1:0]    ramp_ext;
    logic signed [DIFF_W-1:0]    a_raw;
    logic signed [DIFF_W-1:0]    b_raw;
    logic [DUTY_W-1:0]           a_duty;
    logic [DUTY_W-1:0]           b_duty;

    // Stall chain: each stage moves when the one after it is empty or moving
    assign out_adv  = !out_valid_reg || out_ready;
    assign p_ready  = !p_valid_reg || out_adv;
    assign in_ready = p_ready;

    // Gain products
    assign kp_prod = KP_PROD_W'(in_err) * $signed({{(KP_PROD_W-GAIN_W){1'b0}}, kp_q8});
    assign ki_prod = KI_PROD_W'(in_integ) * $signed({{(KI_PROD_W-GAIN_W){1'b0}}, ki_q8});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
        end else if (p_ready) begin
            p_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (p_ready && in_valid) begin
            p_ctrl_reg    <= in_ctrl;
            p_kp_prod_reg <= kp_prod;
            p_ki_prod_reg <= ki_prod;
        end
    end

    // Sum, divide by 256 rounding toward zero, apply around the ramp base
    always_comb begin
        sum        = SUM_W'(p_kp_prod_reg) + SUM_W'(p_ki_prod_reg);
        sum_biased = sum[SUM_W-1] ? (sum + SUM_W'(255)) : sum;
        corr       = CORR_W'(sum_biased >>> 8);
        ramp_ext   = $signed({{(DIFF_W-RAMP_W){1'b0}}, p_ctrl_reg.ramp});
        a_raw      = ramp_ext - DIFF_W'(corr);
        b_raw      = ramp_ext + DIFF_W'(corr);

        if (a_raw[DIFF_W-1]) begin
            a_duty = '0;
        end else if (a_raw > DIFF_W'(DUTY_MAX)) begin
            a_duty = DUTY_W'(DUTY_MAX);
        end else begin
            a_duty = a_raw[DUTY_W-1:0];
        end

        if (b_raw[DIFF_W-1]) begin
            b_duty = '0;
        end else if (b_raw > DIFF_W'(DUTY_MAX)) begin
            b_duty = DUTY_W'(DUTY_MAX);
        end else begin
            b_duty = b_raw[DUTY_W-1:0];
        end

        out_result_next.drive_mode     = p_ctrl_reg.mode;
        out_result_next.duty_update    = p_ctrl_reg.upd;
        out_result_next.clear_encoders = p_ctrl_reg.clr;
        if (p_ctrl_reg.pi_en) begin
            out_result_next.duty_a_fwd = a_duty;
            out_result_next.duty_a_rev = '0;
            out_result_next.duty_b_fwd = b_duty;
            out_result_next.duty_b_rev = '0;
        end else begin
            out_result_next.duty_a_fwd = p_ctrl_reg.duty_a_fwd;
            out_result_next.duty_a_rev = p_ctrl_reg.duty_a_rev;
            out_result_next.duty_b_fwd = p_ctrl_reg.duty_b_fwd;
            out_result_next.duty_b_rev = p_ctrl_reg.duty_b_rev;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_adv) begin
            out_valid_reg <= p_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_adv && p_valid_reg) begin
            out_result_reg <= out_result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = out_result_reg;

endmodule

/* rtl/core/two_motor_speed_sync_pi_top.sv */
// Top level of the two-motor speed sync controller with PI correction and mode button.
// Each transaction passes four registers in order: input, state, multiply, result.
// Throughput: one transaction per cycle while m_ready does not stall the result.
// The state stage updates mode, counts, ramp and integral combinationally, so items run back to back.
// Reset: synchronous, active low; clears all valids and state, loads register defaults.
module two_motor_speed_sync_pi_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [tmss_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tmss_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_kind,
    input  logic [tmss_pkg::CNT_W-1:0]          s_enc_count_a,
    input  logic [tmss_pkg::CNT_W-1:0]          s_enc_count_b,
    input  logic [tmss_pkg::TIME_W-1:0]         s_now_ms,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tmss_pkg::MODE_W-1:0]         m_drive_mode,
    output logic [tmss_pkg::DUTY_W-1:0]         m_duty_a_fwd,
    output logic [tmss_pkg::DUTY_W-1:0]         m_duty_a_rev,
    output logic [tmss_pkg::DUTY_W-1:0]         m_duty_b_fwd,
    output logic [tmss_pkg::DUTY_W-1:0]         m_duty_b_rev,
    output logic                                m_duty_update,
    output logic                                m_clear_encoders
);
    import tmss_pkg::*;

    localparam int ISUM_W = ERR_W + 1;

    // Configuration registers
    logic [DUTY_W-1:0]  target_base_reg;
    logic [DUTY_W-1:0]  ramp_step_reg;
    logic [GAIN_W-1:0]  kp_q8_reg;
    logic [GAIN_W-1:0]  ki_q8_reg;
    logic [LIMIT_W-1:0] integral_limit_reg;
    logic [DUTY_W-1:0]  turn_duty_reg;
    logic [CNT_W-1:0]   debounce_ms_reg;

    // Controller state
    logic [MODE_W-1:0]         mode_reg,       mode_next;
    logic [CNT_W-1:0]          prev_a_reg,     prev_a_next;
    logic [CNT_W-1:0]          prev_b_reg,     prev_b_next;
    logic [RAMP_W-1:0]         ramp_reg,       ramp_next;
    logic signed [INTEG_W-1:0] integ_reg,      integ_next;
    logic [TIME_W-1:0]         last_press_reg, last_press_next;

    // Input register
    logic               in_valid_reg;
    logic               in_kind_reg;
    logic [CNT_W-1:0]   in_count_a_reg;
    logic [CNT_W-1:0]   in_count_b_reg;
    logic [TIME_W-1:0]  in_now_reg;

    // State stage register
    logic                      st_valid_reg;
    tmss_ctrl_t                st_ctrl_reg,  st_ctrl_next;
    logic signed [ERR_W-1:0]   st_err_reg,   st_err_next;
    logic signed [INTEG_W-1:0] st_integ_reg;

    logic                      in_ready;
    logic                      st_ready;
    logic                      dp_in_ready;
    logic                      adv;
    logic                      is_sample;
    logic                      is_button;
    logic                      press_ok;
    logic [TIME_W-1:0]         press_gap;
    logic [MODE_W-1:0]         mode_adv;
    logic [CNT_W-1:0]          speed_a;
    logic [CNT_W-1:0]          speed_b;
    logic signed [ISUM_W-1:0]  isum;
    logic signed [ISUM_W-1:0]  lim_pos;
    logic signed [ISUM_W-1:0]  lim_neg;
    logic [DUTY_W-1:0]         td;
    tmss_result_t              dp_result;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_base_reg    <= DUTY_W'(600);
            ramp_step_reg      <= DUTY_W'(25);
            kp_q8_reg          <= GAIN_W'(1792);
            ki_q8_reg          <= GAIN_W'(51);
            integral_limit_reg <= LIMIT_W'(500);
            turn_duty_reg      <= DUTY_W'(800);
            debounce_ms_reg    <= CNT_W'(200);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TARGET_BASE:    target_base_reg    <= cfg_data[DUTY_W-1:0];
                REG_RAMP_STEP:      ramp_step_reg      <= cfg_data[DUTY_W-1:0];
                REG_KP_Q8:          kp_q8_reg          <= cfg_data[GAIN_W-1:0];
                REG_KI_Q8:          ki_q8_reg          <= cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LIMIT_W-1:0];
                REG_TURN_DUTY:      turn_duty_reg      <= cfg_data[DUTY_W-1:0];
                REG_DEBOUNCE_MS:    debounce_ms_reg    <= cfg_data[CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Stall chain
    assign st_ready = !st_valid_reg || dp_in_ready;
    assign in_ready = !in_valid_reg || st_ready;
    assign s_ready  = in_ready;
    assign adv      = in_valid_reg && st_ready;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && s_valid) begin
            in_kind_reg    <= s_kind;
            in_count_a_reg <= s_enc_count_a;
            in_count_b_reg <= s_enc_count_b;
            in_now_reg     <= s_now_ms;
        end
    end

    // Speeds, error, integral, ramp, mode and duty pattern for one transaction
    always_comb begin
        is_sample = (in_kind_reg == KIND_SAMPLE);
        is_button = (in_kind_reg == KIND_BUTTON);

        press_gap = in_now_reg - last_press_reg;
        press_ok  = press_gap > TIME_W'(debounce_ms_reg);
        mode_adv  = (mode_reg >= MODE_STOP) ? MODE_STRAIGHT : (mode_reg + MODE_W'(1));

        speed_a     = prev_a_reg - in_count_a_reg;
        speed_b     = in_count_b_reg - prev_b_reg;
        st_err_next = $signed({speed_a[CNT_W-1], speed_a}) - $signed({speed_b[CNT_W-1], speed_b});

        isum    = ISUM_W'(integ_reg) + ISUM_W'(st_err_next);
        lim_pos = $signed({{(ISUM_W-LIMIT_W){1'b0}}, integral_limit_reg});
        lim_neg = -lim_pos;

        td = (turn_duty_reg > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : turn_duty_reg;

        // hold state by default
        mode_next       = mode_reg;
        prev_a_next     = prev_a_reg;
        prev_b_next     = prev_b_reg;
        ramp_next       = ramp_reg;
        integ_next      = integ_reg;
        last_press_next = last_press_reg;

        if (is_button) begin
            last_press_next = in_now_reg;
            if (press_ok) begin
                mode_next   = mode_adv;
                prev_a_next = '0;
                prev_b_next = '0;
                ramp_next   = '0;
            end
        end else begin
            prev_a_next = in_count_a_reg;
            prev_b_next = in_count_b_reg;
            if (mode_reg == MODE_STRAIGHT) begin
                if (ramp_reg < RAMP_W'(target_base_reg)) begin
                    ramp_next = ramp_reg + RAMP_W'(ramp_step_reg);
                end
                if (isum > lim_pos) begin
                    integ_next = INTEG_W'(lim_pos);
                end else if (isum < lim_neg) begin
                    integ_next = INTEG_W'(lim_neg);
                end else begin
                    integ_next = INTEG_W'(isum);
                end
            end
        end

        st_ctrl_next.mode       = mode_next;
        st_ctrl_next.upd        = is_sample;
        st_ctrl_next.clr        = is_button && press_ok;
        st_ctrl_next.pi_en      = is_sample && (mode_reg == MODE_STRAIGHT);
        st_ctrl_next.ramp       = ramp_next;
        st_ctrl_next.duty_a_fwd = '0;
        st_ctrl_next.duty_a_rev = '0;
        st_ctrl_next.duty_b_fwd = '0;
        st_ctrl_next.duty_b_rev = '0;
        if (is_sample) begin
            unique case (mode_reg)
                MODE_RIGHT: begin
                    st_ctrl_next.duty_a_fwd = td;
                    st_ctrl_next.duty_b_rev = td;
                end
                MODE_LEFT: begin
                    st_ctrl_next.duty_a_rev = td;
                    st_ctrl_next.duty_b_fwd = td;
                end
                MODE_BACK: begin
                    st_ctrl_next.duty_a_rev = td;
                    st_ctrl_next.duty_b_rev = td;
                end
                default: begin
                end
            endcase
        end
    end

    // Advance controller state when a transaction enters the state stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_STRAIGHT;
            prev_a_reg     <= '0;
            prev_b_reg     <= '0;
            ramp_reg       <= '0;
            integ_reg      <= '0;
            last_press_reg <= '0;
        end else if (adv) begin
            mode_reg       <= mode_next;
            prev_a_reg     <= prev_a_next;
            prev_b_reg     <= prev_b_next;
            ramp_reg       <= ramp_next;
            integ_reg      <= integ_next;
            last_press_reg <= last_press_next;
        end
    end

    // State stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (st_ready) begin
            st_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            st_ctrl_reg  <= st_ctrl_next;
            st_err_reg   <= st_err_next;
            st_integ_reg <= integ_next;
        end
    end

    tmss_pi_datapath u_pi_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .kp_q8      (kp_q8_reg),
        .ki_q8      (ki_q8_reg),
        .in_valid   (st_valid_reg),
        .in_ready   (dp_in_ready),
        .in_ctrl    (st_ctrl_reg),
        .in_err     (st_err_reg),
        .in_integ   (st_integ_reg),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (dp_result)
    );

    assign m_drive_mode     = dp_result.drive_mode;
    assign m_duty_a_fwd     = dp_result.duty_a_fwd;
    assign m_duty_a_rev     = dp_result.duty_a_rev;
    assign m_duty_b_fwd     = dp_result.duty_b_fwd;
    assign m_duty_b_rev     = dp_result.duty_b_rev;
    assign m_duty_update    = dp_result.duty_update;
    assign m_clear_encoders = dp_result.clear_encoders;

endmodule

/* rtl/core/tmss_checker.sv */
// Port-level checker for the motor controller, bound to the top level.
`include "two_motor_speed_sync_pi_top_defines.svh"

module tmss_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [tmss_pkg::MODE_W-1:0]         m_drive_mode,
    input logic [tmss_pkg::DUTY_W-1:0]         m_duty_a_fwd,
    input logic [tmss_pkg::DUTY_W-1:0]         m_duty_a_rev,
    input logic [tmss_pkg::DUTY_W-1:0]         m_duty_b_fwd,
    input logic [tmss_pkg::DUTY_W-1:0]         m_duty_b_rev,
    input logic                                m_duty_update,
    input logic                                m_clear_encoders
);
    import tmss_pkg::*;

    logic                          duties_zero;
    logic                          res_stall;
    logic                          res_sample;
    logic                          res_button;
    logic                          res_stop;
    logic [MODE_W+4*DUTY_W+1:0]    res_bits;

    assign duties_zero = (m_duty_a_fwd == '0) && (m_duty_a_rev == '0) &&
                         (m_duty_b_fwd == '0) && (m_duty_b_rev == '0);
    assign res_stall   = m_valid && !m_ready;
    assign res_sample  = m_valid && m_duty_update;
    assign res_button  = m_valid && !m_duty_update;
    assign res_stop    = m_valid && (m_drive_mode == MODE_STOP);
    assign res_bits    = {m_drive_mode, m_duty_a_fwd, m_duty_a_rev, m_duty_b_fwd,
                          m_duty_b_rev, m_duty_update, m_clear_encoders};

    // A stalled result transaction holds its payload
    `TMSS_ASSERT_NXT(a_result_hold, res_stall, m_valid && $stable(res_bits), "result moved in stall")

    // Encoder clear comes only from button transactions
    `TMSS_ASSERT_IMP(a_clear_on_button, res_sample, !m_clear_encoders, "clear flag on a sample")

    // Button results carry no duty
    `TMSS_ASSERT_IMP(a_button_no_duty, res_button, duties_zero, "duty on a button result")

    // Stop mode drives nothing
    `TMSS_ASSERT_IMP(a_stop_idle, res_stop, duties_zero, "duty in stop mode")

endmodule

bind two_motor_speed_sync_pi_top tmss_checker u_tmss_checker (.*);

/* sim/two_motor_speed_sync_pi_top_tb.sv */
// Self-checking testbench for the two-motor speed sync PI controller top level.
`timescale 1ns / 100ps

// Mirrors the controller state and holds the results still owed by the block
class drive_ctrl_scoreboard;
    // Register copies
    logic [9:0]  target_base;
    logic [9:0]  ramp_step;
    logic [15:0] kp_q8;
    logic [15:0] ki_q8;
    logic [14:0] integ_limit;
    logic [9:0]  turn_duty;
    logic [15:0] debounce_ms;
    // Controller state
    logic [2:0]  mode;
    logic [15:0] prev_a;
    logic [15:0] prev_b;
    logic [10:0] base_duty;
    int          integ;
    logic [31:0] last_press;
    // Outstanding results, oldest first
    tmss_pkg::tmss_result_t owed_results[$];
    int          n_samples;
    int          n_presses;
    int          n_taken;
    int          n_results;
    int          n_errors;
    logic [4:0]  modes_seen;

    function new();
        target_base = 10'd600;
        ramp_step   = 10'd25;
        kp_q8       = 16'd1792;
        ki_q8       = 16'd51;
        integ_limit = 15'd500;
        turn_duty   = 10'd800;
        debounce_ms = 16'd200;
        mode        = tmss_pkg::MODE_STRAIGHT;
        prev_a      = '0;
        prev_b      = '0;
        base_duty   = '0;
        integ       = 0;
        last_press  = '0;
        n_samples   = 0;
        n_presses   = 0;
        n_taken     = 0;
        n_results   = 0;
        n_errors    = 0;
        modes_seen  = '0;
    endfunction

    // Apply a register write; indexes past the list are dropped
    function void set_reg(logic [tmss_pkg::CFG_INDEX_W-1:0] index,
                          logic [tmss_pkg::CFG_DATA_W-1:0] data);
        case (index)
            tmss_pkg::REG_TARGET_BASE:    target_base = data[9:0];
            tmss_pkg::REG_RAMP_STEP:      ramp_step   = data[9:0];
            tmss_pkg::REG_KP_Q8:          kp_q8       = data;
            tmss_pkg::REG_KI_Q8:          ki_q8       = data;
            tmss_pkg::REG_INTEGRAL_LIMIT: integ_limit = data[14:0];
            tmss_pkg::REG_TURN_DUTY:      turn_duty   = data[9:0];
            tmss_pkg::REG_DEBOUNCE_MS:    debounce_ms = data;
            default: ;
        endcase
    endfunction

    function logic [9:0] clamp_duty(longint v);
        if (v < 0)
            return '0;
        if (v > tmss_pkg::DUTY_MAX)
            return 10'(tmss_pkg::DUTY_MAX);
        return v[9:0];
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    // Advance the controller by one accepted transaction and queue its result
    function void note_item(logic kind, logic [15:0] cnt_a, logic [15:0] cnt_b,
                            logic [31:0] now);
        tmss_pkg::tmss_result_t r;
        logic [31:0] elapsed;
        logic [15:0] delta_a;
        logic [15:0] delta_b;
        logic [9:0]  fixed_duty;
        longint      err;
        longint      acc;
        longint      corr;
        r = '0;
        if (kind == tmss_pkg::KIND_BUTTON) begin
            n_presses++;
            elapsed = now - last_press;
            if (elapsed > {16'd0, debounce_ms}) begin
                mode = (mode >= tmss_pkg::MODE_STOP) ? tmss_pkg::MODE_STRAIGHT : mode + 3'd1;
                prev_a = '0;
                prev_b = '0;
                base_duty = '0;
                r.clear_encoders = 1'b1;
                n_taken++;
            end
            last_press = now;
        end else begin
            n_samples++;
            // motor 1 counts the other way round
            delta_a = prev_a - cnt_a;
            delta_b = cnt_b - prev_b;
            prev_a = cnt_a;
            prev_b = cnt_b;
            r.duty_update = 1'b1;
            modes_seen[mode] = 1'b1;
            fixed_duty = (turn_duty > tmss_pkg::DUTY_MAX) ? 10'(tmss_pkg::DUTY_MAX) : turn_duty;
            case (mode)
                tmss_pkg::MODE_STRAIGHT: begin
                    if (base_duty < {1'b0, target_base})
                        base_duty = base_duty + {1'b0, ramp_step};
                    err = longint'($signed(delta_a)) - longint'($signed(delta_b));
                    acc = longint'(integ) + err;
                    if (acc > longint'(integ_limit))
                        acc = longint'(integ_limit);
                    else if (acc < -longint'(integ_limit))
                        acc = -longint'(integ_limit);
                    integ = int'(acc);
                    // Q8.8 gains, quotient truncates toward zero
                    corr = (err * longint'(kp_q8) + longint'(integ) * longint'(ki_q8)) / 256;
                    r.duty_a_fwd = clamp_duty(longint'(base_duty) - corr);
                    r.duty_b_fwd = clamp_duty(longint'(base_duty) + corr);
                end
                tmss_pkg::MODE_RIGHT: begin
                    r.duty_a_fwd = fixed_duty;
                    r.duty_b_rev = fixed_duty;
                end
                tmss_pkg::MODE_LEFT: begin
                    r.duty_a_rev = fixed_duty;
                    r.duty_b_fwd = fixed_duty;
                end
                tmss_pkg::MODE_BACK: begin
                    r.duty_a_rev = fixed_duty;
                    r.duty_b_rev = fixed_duty;
                end
                default: ;
            endcase
        end
        r.drive_mode = mode;
        owed_results.push_back(r);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch on result %0d: expected %0d, actual %0d",
                   name, n_results, want, got);
            n_errors++;
        end
    endfunction

    // Compare one result transaction with the oldest owed result
    function void check_result(tmss_pkg::tmss_result_t got);
        tmss_pkg::tmss_result_t want;
        n_results++;
        if (owed_results.size() == 0) begin
            $error("result %0d arrived with nothing outstanding (drive_mode %0d)",
                   n_results, got.drive_mode);
            n_errors++;
            return;
        end
        want = owed_results.pop_front();
        compare_field("drive_mode", want.drive_mode, got.drive_mode);
        compare_field("duty_a_fwd", want.duty_a_fwd, got.duty_a_fwd);
        compare_field("duty_a_rev", want.duty_a_rev, got.duty_a_rev);
        compare_field("duty_b_fwd", want.duty_b_fwd, got.duty_b_fwd);
        compare_field("duty_b_rev", want.duty_b_rev, got.duty_b_rev);
        compare_field("duty_update", want.duty_update, got.duty_update);
        compare_field("clear_encoders", want.clear_encoders, got.clear_encoders);
    endfunction
endclass

module two_motor_speed_sync_pi_top_tb;
    import tmss_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
    localparam int ITEMS_PER_PHASE = 120;
    localparam int SETTLE_CYCLES   = 6;
    // Receiver stall patterns
    localparam int RX_FREE     = 0;
    localparam int RX_RANDOM   = 1;
    localparam int RX_SPARSE   = 2;
    localparam int RX_PERIODIC = 3;

    logic                   aclk;
    logic                   aresetn          = 1'b0;
    logic                   cfg_wr_en        = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index        = '0;
    logic [CFG_DATA_W-1:0]  cfg_data         = '0;
    logic                   s_valid          = 1'b0;
    logic                   s_ready;
    logic                   s_kind           = KIND_SAMPLE;
    logic [CNT_W-1:0]       s_enc_count_a    = '0;
    logic [CNT_W-1:0]       s_enc_count_b    = '0;
    logic [TIME_W-1:0]      s_now_ms         = '0;
    logic                   m_valid;
    logic                   m_ready          = 1'b0;
    logic [MODE_W-1:0]      m_drive_mode;
    logic [DUTY_W-1:0]      m_duty_a_fwd;
    logic [DUTY_W-1:0]      m_duty_a_rev;
    logic [DUTY_W-1:0]      m_duty_b_fwd;
    logic [DUTY_W-1:0]      m_duty_b_rev;
    logic                   m_duty_update;
    logic                   m_clear_encoders;

    drive_ctrl_scoreboard sb;

    // Encoder and time stimulus state
    logic [15:0] enc_a;
    logic [15:0] enc_b;
    logic [31:0] clock_ms;
    int          wheel_speed;
    int          n_settings;
    // Receiver pattern state
    int          rx_kind = RX_FREE;
    int          rx_left = 0;
    int          rx_tick = 0;

    two_motor_speed_sync_pi_top u_top (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Run timed out with %0d results outstanding", sb.pending());
        $display("TB_ERROR");
        $finish;
    end

    // Check each result transaction, then pick the next ready level
    always @(posedge aclk) begin
        tmss_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.drive_mode     = m_drive_mode;
            got.duty_a_fwd     = m_duty_a_fwd;
            got.duty_a_rev     = m_duty_a_rev;
            got.duty_b_fwd     = m_duty_b_fwd;
            got.duty_b_rev     = m_duty_b_rev;
            got.duty_update    = m_duty_update;
            got.clear_encoders = m_clear_encoders;
            sb.check_result(got);
        end
        if (rx_left == 0) begin
            rx_kind = $urandom_range(RX_FREE, RX_PERIODIC);
            rx_left = $urandom_range(8, 64);
        end else begin
            rx_left--;
        end
        rx_tick++;
        case (rx_kind)
            RX_FREE:     m_ready <= 1'b1;
            RX_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE:   m_ready <= ($urandom_range(0, 5) == 0);
            default:     m_ready <= (rx_tick % 5 != 0);
        endcase
    end

    // Present one transaction and hold it until accepted
    task automatic send_item(input logic kind, input logic [15:0] cnt_a,
                             input logic [15:0] cnt_b, input logic [31:0] now);
        s_kind        <= kind;
        s_enc_count_a <= cnt_a;
        s_enc_count_b <= cnt_b;
        s_now_ms      <= now;
        s_valid       <= 1'b1;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sb.note_item(kind, cnt_a, cnt_b, now);
    endtask

    task automatic idle_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(posedge aclk);
    endtask

    // Hold off the sender until every owed result is back, then let the pipe settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        sb.set_reg(index, data);
    endtask

    // Write the whole register set back to back, optionally poking the unused index
    task automatic load_settings(input logic [15:0] tgt, input logic [15:0] step,
                                 input logic [15:0] kp, input logic [15:0] ki,
                                 input logic [15:0] lim, input logic [15:0] turn,
                                 input logic [15:0] deb, input bit poke_unmapped);
        write_reg(REG_TARGET_BASE, tgt);
        write_reg(REG_RAMP_STEP, step);
        write_reg(REG_KP_Q8, kp);
        write_reg(REG_KI_Q8, ki);
        write_reg(REG_INTEGRAL_LIMIT, lim);
        write_reg(REG_TURN_DUTY, turn);
        write_reg(REG_DEBOUNCE_MS, deb);
        if (poke_unmapped)
            write_reg(REG_UNMAPPED, 16'($urandom));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        n_settings++;
    endtask

    // Build the next transaction: mostly plausible wheel motion and debounced presses
    task automatic next_item(output logic kind, output logic [15:0] cnt_a,
                             output logic [15:0] cnt_b, output logic [31:0] now);
        int          pick;
        int          drift;
        int          jitter;
        int          noise_a;
        int          noise_b;
        logic [31:0] step_ms;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            kind  = KIND_BUTTON;
            cnt_a = 16'($urandom);
            cnt_b = 16'($urandom);
            pick  = $urandom_range(0, 99);
            if (pick < 8) begin
                clock_ms = $urandom;
            end else begin
                if (pick < 13)
                    step_ms = sb.debounce_ms;
                else if (pick < 18)
                    step_ms = sb.debounce_ms + 1;
                else if (pick < 35)
                    step_ms = $urandom_range(0, sb.debounce_ms);
                else
                    step_ms = sb.debounce_ms + 1 + $urandom_range(0, 2000);
                clock_ms = clock_ms + step_ms;
            end
            now = clock_ms;
            // the block zeroes its counts on a taken press; the encoders are zeroed on every press
            enc_a = '0;
            enc_b = '0;
            wheel_speed = 0;
        end else begin
            kind = KIND_SAMPLE;
            now  = $urandom;
            clock_ms = clock_ms + 25;
            if (pick < 17) begin
                enc_a = 16'($urandom);
                enc_b = 16'($urandom);
            end else begin
                drift = $urandom_range(0, 60);
                wheel_speed = wheel_speed + drift - 30;
                if (wheel_speed > 2000)
                    wheel_speed = 2000;
                else if (wheel_speed < -2000)
                    wheel_speed = -2000;
                jitter  = (pick < 22) ? 2500 : 12;
                noise_a = $urandom_range(0, 2 * jitter);
                noise_b = $urandom_range(0, 2 * jitter);
                enc_a = enc_a - 16'(wheel_speed + noise_a - jitter);
                enc_b = enc_b + 16'(wheel_speed + noise_b - jitter);
            end
            cnt_a = enc_a;
            cnt_b = enc_b;
        end
    endtask

    // Random traffic, in bursts when bursty is set, with an occasional full drain
    task automatic run_phase(input int n_items, input bit bursty);
        logic        kind;
        logic [15:0] ca;
        logic [15:0] cb;
        logic [31:0] now;
        int          burst_left;
        burst_left = $urandom_range(1, 24);
        repeat (n_items) begin
            next_item(kind, ca, cb, now);
            send_item(kind, ca, cb, now);
            burst_left--;
            if ($urandom_range(0, 149) == 0) begin
                wait_drained();
            end else if (bursty && burst_left <= 0) begin
                idle_sender($urandom_range(1, 8));
                burst_left = $urandom_range(1, 24);
            end
        end
        wait_drained();
    endtask

    initial begin
        sb = new();
        enc_a = '0;
        enc_b = '0;
        clock_ms = '0;
        wheel_speed = 0;
        n_settings = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Straight mode at reset settings: count extremes and wrap of the deltas
        send_item(KIND_SAMPLE, 16'h0000, 16'h0000, 32'h0000_0000);
        send_item(KIND_SAMPLE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        send_item(KIND_SAMPLE, 16'h8000, 16'h7FFF, 32'h0000_0000);
        send_item(KIND_SAMPLE, 16'h0000, 16'h0000, 32'h5555_5555);
        send_item(KIND_SAMPLE, 16'h7FFF, 16'h8000, 32'hAAAA_AAAA);
        // Presses inside and exactly at the debounce window are dropped
        send_item(KIND_BUTTON, 16'hFFFF, 16'hFFFF, 32'd0);
        send_item(KIND_BUTTON, 16'h0000, 16'h0000, 32'd200);
        // Walk every mode, sampling each; stop mode drives nothing
        send_item(KIND_BUTTON, 16'h1234, 16'h4321, 32'd401);
        send_item(KIND_SAMPLE, 16'd10, 16'd20, 32'd0);
        send_item(KIND_BUTTON, 16'h0000, 16'h0000, 32'd602);
        send_item(KIND_SAMPLE, 16'd30, 16'd40, 32'd0);
        send_item(KIND_BUTTON, 16'h0000, 16'h0000, 32'd803);
        send_item(KIND_SAMPLE, 16'd50, 16'd60, 32'd0);
        send_item(KIND_BUTTON, 16'h0000, 16'h0000, 32'd1004);
        send_item(KIND_SAMPLE, 16'd70, 16'd80, 32'd0);
        // Mode wraps from stop back to straight; time wraps through zero
        send_item(KIND_BUTTON, 16'h0000, 16'h0000, 32'hFFFF_FF00);
        send_item(KIND_SAMPLE, 16'hFFF0, 16'h0010, 32'd0);
        send_item(KIND_BUTTON, 16'h0000, 16'h0000, 32'h0000_0010);
        send_item(KIND_BUTTON, 16'h0000, 16'h0000, 32'h0000_0020);
        send_item(KIND_SAMPLE, 16'd5, 16'd5, 32'd0);
        wait_drained();
        clock_ms = 32'h0000_0020;

        // Upper extremes: turn duty above the duty limit, no debounce
        load_settings(16'd1000, 16'd1000, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'd1023, 16'd0, 1'b0);
        run_phase(ITEMS_PER_PHASE, 1'b0);
        // Lower extremes: zero ramp step and gains, longest debounce
        load_settings(16'd1000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 1'b1);
        run_phase(ITEMS_PER_PHASE, 1'b1);
        load_settings(16'd0, 16'd1, 16'd256, 16'd256, 16'd1, 16'd1000, 16'd1, 1'b0);
        run_phase(ITEMS_PER_PHASE, 1'b1);
        repeat (3) begin
            load_settings(16'($urandom), 16'($urandom), 16'($urandom_range(0, 3000)),
                          16'($urandom_range(0, 3000)), 16'($urandom), 16'($urandom),
                          16'($urandom), 1'b1);
            run_phase(ITEMS_PER_PHASE, 1'b1);
        end
        load_settings(16'd600, 16'd25, 16'd1792, 16'd51, 16'd500, 16'd800, 16'd200, 1'b0);
        run_phase(ITEMS_PER_PHASE, 1'b1);

        $display("Sent %0d samples and %0d button presses (%0d taken) over %0d register sets",
                 sb.n_samples, sb.n_presses, sb.n_taken, n_settings);
        $display("Checked %0d results, %0d failed; modes seen on samples %b",
                 sb.n_results, sb.n_errors, sb.modes_seen);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/tmss_pkg.sv
rtl/core/tmss_pi_datapath.sv
rtl/core/two_motor_speed_sync_pi_top.sv
rtl/core/tmss_checker.sv
sim/two_motor_speed_sync_pi_top_tb.sv
